/* hdl/sb2da_pkg.sv */
// Shared constants and helpers for the signed binary to decimal ASCII converter.
package sb2da_pkg;

   localparam int NUM_W           = 18;
   localparam int CHAR_W          = 8;
   localparam int DIGIT_W         = 4;
   localparam int DIGIT_COUNT_DEF = 5;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   // 10^n as a 64-bit constant; used at elaboration only
   function automatic logic [63:0] pow10(input int unsigned n);
      logic [63:0] acc;
      acc = 64'd1;
      for (int unsigned i = 0; i < n; i++) begin
         acc = acc * 64'd10;
      end
      return acc;
   endfunction

endpackage

/* hdl/sb2da_if.sv */
// Valid/ready channel interfaces for the number input and the character output.
interface sb2da_req_if import sb2da_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [NUM_W-1:0] number_in;

   modport source (output valid, output number_in, input ready);
   modport sink   (input valid, input number_in, output ready);
endinterface

interface sb2da_rsp_if import sb2da_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] text_char;
   logic              last_char;

   modport source (output valid, output text_char, output last_char, input ready);
   modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

/* hdl/signed_binary_to_decimal_ascii.sv */
// Signed integer to decimal ASCII text, one character per output item.
//
// Each input item is a signed 18-bit integer; the block emits its decimal
// text as one ASCII character per output item: a minus sign first for a
// negative value, then the digits with leading zeros dropped ('0' alone for
// zero), last_char high on the final character. Magnitudes above
// 10^DIGIT_COUNT - 1 print as all nines. A number of n characters (1 to
// DIGIT_COUNT + 1) goes out one digit per cycle while the sink does not
// stall, from a compare bank against the multiples of the current power
// of ten. An input register takes the next number while the current one
// is still being emitted, and an output register holds a character while
// the sink stalls, so numbers stream without gaps between them.
module signed_binary_to_decimal_ascii
   import sb2da_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sb2da_req_if.sink   req_bus,
   sb2da_rsp_if.source rsp_bus
);

   localparam int          MAG_W = NUM_W;
   localparam int          POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [63:0] LIMIT = pow10(DIGIT_COUNT) - 64'd1;

   logic [63:0] pow_tab [DIGIT_COUNT];

   for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_pow
      assign pow_tab[g] = pow10(g);
   end

   // input register
   logic             in_valid_ff;
   logic             in_neg_ff;
   logic [MAG_W-1:0] in_mag_ff;
   logic             in_neg_in;
   logic [MAG_W-1:0] in_mag_in;

   // emitter
   logic             busy_ff;
   logic             sign_ff;
   logic [POS_W-1:0] pos_ff;
   logic [MAG_W-1:0] mag_ff;

   // output register
   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              last_ff;
   logic [CHAR_W-1:0] char_in;
   logic              last_in;

   logic               req_take;
   logic               out_free;
   logic               emit;
   logic               load;
   logic [POS_W-1:0]   start_pos;
   logic [DIGIT_W-1:0] digit;
   logic [63:0]        sub_val;
   logic [63:0]        pow_sel;

   // magnitude and saturation on the way into the input register
   always_comb begin
      logic [MAG_W-1:0] raw_mag;
      in_neg_in = req_bus.number_in[NUM_W-1];
      raw_mag   = in_neg_in ? MAG_W'(-req_bus.number_in) : MAG_W'(req_bus.number_in);
      in_mag_in = (64'(raw_mag) > LIMIT) ? LIMIT[MAG_W-1:0] : raw_mag;
   end

   // highest nonzero digit position
   always_comb begin
      start_pos = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (64'(in_mag_ff) >= pow_tab[i]) begin
            start_pos = POS_W'(i);
         end
      end
   end

   // digit at the current position
   always_comb begin
      logic [63:0] mult;
      pow_sel = pow_tab[pos_ff];
      digit   = '0;
      sub_val = '0;
      for (int k = 1; k < 10; k++) begin
         mult = 64'(k) * pow_sel;
         if (64'(mag_ff) >= mult) begin
            digit   = DIGIT_W'(k);
            sub_val = mult;
         end
      end
   end

   always_comb begin
      out_free = !rsp_valid_ff || rsp_bus.ready;
      emit     = busy_ff && out_free;
      char_in  = sign_ff ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(digit));
      last_in  = !sign_ff && (pos_ff == '0);
      load     = in_valid_ff && (!busy_ff || (emit && last_in));
      req_take = req_bus.valid && req_bus.ready;
   end

   assign req_bus.ready     = !in_valid_ff || load;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.text_char = char_ff;
   assign rsp_bus.last_char = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (load) begin
            in_valid_ff <= 1'b0;
         end

         if (load) begin
            busy_ff <= 1'b1;
         end else if (emit && last_in) begin
            busy_ff <= 1'b0;
         end

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_neg_ff <= in_neg_in;
         in_mag_ff <= in_mag_in;
      end

      if (load) begin
         sign_ff <= in_neg_ff;
         pos_ff  <= start_pos;
         mag_ff  <= in_mag_ff;
      end else if (emit) begin
         if (sign_ff) begin
            sign_ff <= 1'b0;
         end else begin
            pos_ff <= pos_ff - POS_W'(1);
            mag_ff <= mag_ff - sub_val[MAG_W-1:0];
         end
      end

      if (emit) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

endmodule

/* tb/sv/tb_signed_binary_to_decimal_ascii.sv */
// Testbench: signed integers in, decimal ASCII characters out, checked by a local predictor.
module tb_signed_binary_to_decimal_ascii;
   import sb2da_pkg::*;

   localparam int DIGITS      = DIGIT_COUNT_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 46;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last_char;
   } text_item_type;

   typedef struct {
      int    number;
      string text;   // empty: take the predictor's text
   } directed_row_type;

   logic clock      = 1'b0;
   logic reset      = 1'b1;
   logic sink_ready = 1'b0;

   int src_idle_pct  = 24;
   int sink_idle_pct = 70;
   int error_count   = 0;
   int numbers_sent  = 0;
   int chars_checked = 0;
   int cycle_count   = 0;

   text_item_type expected_chars[$];
   text_item_type oldest;

   directed_row_type directed_rows[] = '{
      '{0,       "0"},
      '{1,       "1"},
      '{-1,      "-1"},
      '{99999,   "99999"},
      '{-99999,  "-99999"},
      '{131071,  "99999"},
      '{-131072, "-99999"},
      '{100000,  "99999"},
      '{-100000, "-99999"},
      '{10000,   "10000"},
      '{-10000,  ""},
      '{9,       ""},
      '{10,      ""},
      '{99,      ""},
      '{100,     ""},
      '{1000,    ""},
      '{9999,    ""},
      '{-5,      ""},
      '{12345,   ""},
      '{-54321,  ""},
      '{10203,   ""},
      '{-90001,  ""},
      '{1001,    ""}
   };

   sb2da_req_if req_bus ();
   sb2da_rsp_if rsp_bus ();

   signed_binary_to_decimal_ascii #(.DIGIT_COUNT(DIGITS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   assign rsp_bus.ready = sink_ready;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // decimal text of one number: sign, digits without leading zeros, saturated at all nines
   function automatic void predict_text(input logic signed [NUM_W-1:0] number);
      int            mag;
      int            weight;
      int            cap;
      int            digit;
      bit            started;
      text_item_type item;
      mag = (number < 0) ? -int'(number) : int'(number);
      weight = 1;
      for (int i = 1; i < DIGITS; i++) weight *= 10;
      cap = weight * 10 - 1;
      if (mag > cap) mag = cap;
      started = 1'b0;
      if (mag == 0) begin
         item.text_char = ASCII_ZERO;
         item.last_char = 1'b1;
         expected_chars.push_back(item);
         return;
      end
      if (number < 0) begin
         item.text_char = ASCII_MINUS;
         item.last_char = 1'b0;
         expected_chars.push_back(item);
      end
      for (; weight > 0; weight /= 10) begin
         digit = mag / weight;
         if (digit != 0 || started) begin
            item.text_char = ASCII_ZERO + CHAR_W'(digit);
            item.last_char = 1'b0;
            expected_chars.push_back(item);
            mag -= digit * weight;
            started = 1'b1;
         end
      end
      expected_chars[expected_chars.size() - 1].last_char = 1'b1;
   endfunction

   function automatic void expect_typed_text(input string text);
      text_item_type item;
      for (int i = 0; i < text.len(); i++) begin
         item.text_char = text[i];
         item.last_char = (i == text.len() - 1);
         expected_chars.push_back(item);
      end
   endfunction

   // mostly in-range values spread over every digit count; some raw 18-bit patterns
   function automatic logic signed [NUM_W-1:0] random_number();
      int lo;
      int hi;
      int mag;
      int decades;
      if ($urandom_range(9) == 0) return NUM_W'($urandom);
      decades = $urandom_range(DIGITS, 1);
      lo = 1;
      for (int i = 1; i < decades; i++) lo *= 10;
      hi = lo * 10 - 1;
      if (decades == 1) lo = 0;
      mag = $urandom_range(hi, lo);
      return NUM_W'($urandom_range(1) ? -mag : mag);
   endfunction

   // returns in the step where the item was accepted; valid stays high for a back-to-back item
   task automatic send_number(input logic signed [NUM_W-1:0] number, input string text);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid     <= 1'b0;
         req_bus.number_in <= NUM_W'($urandom);
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.number_in <= number;
      do @(posedge clock); while (!req_bus.ready);
      if (text.len() != 0) expect_typed_text(text);
      else predict_text(number);
      numbers_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            $error("unexpected item: text_char %h last_char %b",
                   rsp_bus.text_char, rsp_bus.last_char);
            error_count++;
         end else begin
            oldest = expected_chars.pop_front();
            if (rsp_bus.text_char !== oldest.text_char) begin
               $error("text_char: expected %h, got %h", oldest.text_char, rsp_bus.text_char);
               error_count++;
            end
            if (rsp_bus.last_char !== oldest.last_char) begin
               $error("last_char: expected %b, got %b", oldest.last_char, rsp_bus.last_char);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.number_in <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_number(NUM_W'(directed_rows[i].number), directed_rows[i].text);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin src_idle_pct = 24; sink_idle_pct = 70; end
            1: begin src_idle_pct = 70; sink_idle_pct = 24; end
            default: begin src_idle_pct = 0; sink_idle_pct = 0; end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_number(random_number(), "");
         end
      end
      req_bus.valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DIGITS + 8) @(posedge clock);

      $display("Sent %0d numbers (zero, sign, saturation, every digit count, raw patterns),",
               numbers_sent);
      $display("checked %0d characters under three idle/stall mixes.", chars_checked);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
